// ===== design/hm_pkg.sv =====
// hm_pkg: constants shared by the heat-map hue to rgb block
// register indexes, reset values and fixed-point constants
// no dependencies
package hm_pkg;

   localparam int unsigned FRAC_W = 16;        // q0.16 field width
   localparam int unsigned CSR_INDEX_W = 1;    // two registers

   typedef logic [FRAC_W-1:0] frac_type;
   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   // register indexes
   localparam csr_index_type CSR_SATURATION = 1'b0;
   localparam csr_index_type CSR_BRIGHTNESS = 1'b1;

   // reset values, 0.8 in q0.16
   localparam frac_type SATURATION_RESET = 16'd52429;
   localparam frac_type BRIGHTNESS_RESET = 16'd52429;

   // one in q0.16 needs 17 bits
   localparam logic [FRAC_W:0] HM_ONE = 17'h10000;
   localparam frac_type HM_MAX = 16'hFFFF;

   // hue in sixths: hp = floor(d * 39 / 10), d = 1 - level
   // done as (d * 39 * ceil(2^26 / 10)) >> 26, exact for d <= 2^16
   localparam int unsigned HUE_SHIFT = 26;
   localparam logic [27:0] HUE_MULT = 28'd261724593;
   localparam int unsigned HUE_PROD_W = (FRAC_W + 1) + 28;
   localparam int unsigned HP_W = 18;          // q2.16 hue
   localparam logic [HP_W-1:0] HP_MAX = 18'd255590;

   typedef logic [1:0] sector_type;
   localparam sector_type SECTOR_RED_YELLOW = 2'd0;
   localparam sector_type SECTOR_YELLOW_GREEN = 2'd1;
   localparam sector_type SECTOR_GREEN_CYAN = 2'd2;
   localparam sector_type SECTOR_CYAN_BLUE = 2'd3;

endpackage

// ===== design/heatmap_hue_to_rgb.sv =====
// heatmap_hue_to_rgb: five-stage pipelined heat-map colour mapper
// depends on hm_pkg for register indexes and fixed-point constants
//
// usage: drive req_level and pulse start; an item is taken at each rising
// edge with start high and busy low. busy stays low, so one item can enter
// every cycle and the block sustains one item per clock.
// results: the result of each item taken shows on rsp_red, rsp_green
// and rsp_blue with rsp_valid high for a single cycle once it leaves stage 5.
// stages: 1 register 1 - level, 2 hue multiply by 3.9 (reciprocal multiply),
// 3 sector and ramp factor, 4 x = chroma * factor, 5 select and add m.
// the 17x28 hue multiply and the 16x17 ramp multiply set the stage depth.
// saturation and brightness are written through csr_we/csr_index/csr_wdata;
// chroma and m are recomputed from them, in chroma_ff and then offset_ff, so a write must be
// made with no item in flight.
// reset: synchronous, clears the valid pipeline and loads both registers
// with 0.8; nothing is stored for items caught in flight.
// the receiver cannot stall: each result is shown for one cycle only.
module heatmap_hue_to_rgb (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  hm_pkg::frac_type       req_level,
   output logic                   rsp_valid,
   output hm_pkg::frac_type       rsp_red,
   output hm_pkg::frac_type       rsp_green,
   output hm_pkg::frac_type       rsp_blue,
   input  logic                   csr_we,
   input  hm_pkg::csr_index_type  csr_index,
   input  hm_pkg::frac_type       csr_wdata
);
   import hm_pkg::*;

   localparam int unsigned STAGES = 5;

   // ---------------- configuration registers ----------------
   frac_type saturation_ff, saturation_in;
   frac_type brightness_ff, brightness_in;

   always_comb begin
      saturation_in = saturation_ff;
      brightness_in = brightness_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_SATURATION: saturation_in = csr_wdata;
            CSR_BRIGHTNESS: brightness_in = csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         saturation_ff <= SATURATION_RESET;
         brightness_ff <= BRIGHTNESS_RESET;
      end else begin
         saturation_ff <= saturation_in;
         brightness_ff <= brightness_in;
      end
   end

   // chroma = v*s and m = v - chroma, recomputed every cycle
   logic [2*FRAC_W-1:0] chroma_prod;
   frac_type chroma_ff, chroma_in;
   frac_type offset_ff, offset_in;

   assign chroma_prod = brightness_ff * saturation_ff;
   assign chroma_in = chroma_prod[2*FRAC_W-1:FRAC_W];
   assign offset_in = brightness_ff - chroma_ff;   // not negative once chroma_ff has followed a brightness write

   always_ff @(posedge clock) begin
      chroma_ff <= chroma_in;
      offset_ff <= offset_in;
   end

   // ---------------- valid pipeline ----------------
   logic accept;
   logic [STAGES-1:0] valid_ff, valid_in;

   assign busy = 1'b0;
   assign accept = start && !busy;
   assign valid_in = {valid_ff[STAGES-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // ---------------- stage 1: distance from one ----------------
   logic [FRAC_W:0] dist_ff, dist_in;

   assign dist_in = HM_ONE - {1'b0, req_level};

   always_ff @(posedge clock) begin
      dist_ff <= dist_in;
   end

   // ---------------- stage 2: hue in sixths, q2.16 ----------------
   logic [HUE_PROD_W-1:0] hue_prod;
   logic [HP_W-1:0] hue_ff, hue_in;

   assign hue_prod = dist_ff * HUE_MULT;
   assign hue_in = hue_prod[HUE_SHIFT+HP_W-1:HUE_SHIFT];

   always_ff @(posedge clock) begin
      hue_ff <= hue_in;
   end

   // ---------------- stage 3: sector and ramp factor ----------------
   sector_type sector3_ff, sector3_in;
   logic [FRAC_W:0] factor_ff, factor_in;

   assign sector3_in = hue_ff[HP_W-1:FRAC_W];
   // rising ramp in even sectors, falling in odd ones
   assign factor_in = sector3_in[0] ? (HM_ONE - {1'b0, hue_ff[FRAC_W-1:0]})
                                    : {1'b0, hue_ff[FRAC_W-1:0]};

   always_ff @(posedge clock) begin
      sector3_ff <= sector3_in;
      factor_ff  <= factor_in;
   end

   // ---------------- stage 4: x = chroma * factor ----------------
   logic [2*FRAC_W:0] ramp_prod;
   sector_type sector4_ff;
   frac_type ramp_ff, ramp_in;

   assign ramp_prod = chroma_ff * factor_ff;
   assign ramp_in = ramp_prod[2*FRAC_W-1:FRAC_W];   // product stays below 2^32

   always_ff @(posedge clock) begin
      sector4_ff <= sector3_ff;
      ramp_ff    <= ramp_in;
   end

   // ---------------- stage 5: component select, add m, clamp ----------------
   frac_type red_base, green_base, blue_base;
   logic [FRAC_W:0] red_sum, green_sum, blue_sum;
   frac_type red_in, green_in, blue_in;
   frac_type red_ff, green_ff, blue_ff;

   always_comb begin
      red_base   = '0;
      green_base = '0;
      blue_base  = '0;
      unique case (sector4_ff)
         SECTOR_RED_YELLOW: begin
            red_base   = chroma_ff;
            green_base = ramp_ff;
         end
         SECTOR_YELLOW_GREEN: begin
            red_base   = ramp_ff;
            green_base = chroma_ff;
         end
         SECTOR_GREEN_CYAN: begin
            green_base = chroma_ff;
            blue_base  = ramp_ff;
         end
         SECTOR_CYAN_BLUE: begin
            green_base = ramp_ff;
            blue_base  = chroma_ff;
         end
      endcase
   end

   assign red_sum   = {1'b0, red_base} + {1'b0, offset_ff};
   assign green_sum = {1'b0, green_base} + {1'b0, offset_ff};
   assign blue_sum  = {1'b0, blue_base} + {1'b0, offset_ff};

   // clamp is a safeguard, the sum never exceeds brightness
   assign red_in   = red_sum[FRAC_W] ? HM_MAX : red_sum[FRAC_W-1:0];
   assign green_in = green_sum[FRAC_W] ? HM_MAX : green_sum[FRAC_W-1:0];
   assign blue_in  = blue_sum[FRAC_W] ? HM_MAX : blue_sum[FRAC_W-1:0];

   always_ff @(posedge clock) begin
      red_ff   <= red_in;
      green_ff <= green_in;
      blue_ff  <= blue_in;
   end

   assign rsp_valid = valid_ff[STAGES-1];
   assign rsp_red   = red_ff;
   assign rsp_green = green_ff;
   assign rsp_blue  = blue_ff;

`ifndef SYNTHESIS
   // an accepted item enters stage 1 on the next edge
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $past(accept)) |-> valid_ff[0])
      else $error("accepted item did not enter the pipeline");

   // every result traces back to an item accepted into the pipeline
   a_result_traced: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, STAGES))
      else $error("result without a matching item");

   // hue stays within the sectors a 16-bit level can reach
   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff[1] |-> (hue_ff <= HP_MAX))
      else $error("hue out of range");

   // ramp factor never exceeds one
   a_factor_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff[2] |-> (factor_ff <= HM_ONE))
      else $error("ramp factor above one");
`endif

endmodule

// ===== sim/heatmap_hue_to_rgb_tb.sv =====
// heatmap_hue_to_rgb_tb: self-checking bench for the heat-map hue to rgb mapper
// predicts each colour in fixed point and checks it against the result strobe
// depends on hm_pkg and heatmap_hue_to_rgb
module heatmap_hue_to_rgb_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import hm_pkg::*;

   localparam int unsigned PIPE_DEPTH = 5;         // stages in the dut pipeline
   localparam int unsigned SETTLE_CYCLES = PIPE_DEPTH + 3;
   localparam int unsigned CYCLE_LIMIT = 500000;
   localparam int unsigned RANDOM_PHASES = 6;
   localparam int unsigned ITEMS_PER_PHASE = 175;
   localparam int unsigned MAX_REPORTS = 10;

   // six hue sectors of the colour circle, only the first four reachable
   typedef enum int {
      HUE_RED_YELLOW,
      HUE_YELLOW_GREEN,
      HUE_GREEN_CYAN,
      HUE_CYAN_BLUE,
      HUE_BLUE_MAGENTA,
      HUE_MAGENTA_RED
   } hue_sector_type;

   typedef struct packed {
      frac_type red;
      frac_type green;
      frac_type blue;
   } color_type;

   logic          clock;
   logic          reset = 1'b1;
   logic          start = 1'b0;
   logic          busy;
   frac_type      req_level = '0;
   logic          rsp_valid;
   frac_type      rsp_red;
   frac_type      rsp_green;
   frac_type      rsp_blue;
   logic          csr_we = 1'b0;
   csr_index_type csr_index = CSR_SATURATION;
   frac_type      csr_wdata = '0;

   // bench copy of the two colour registers
   frac_type cfg_saturation = SATURATION_RESET;
   frac_type cfg_brightness = BRIGHTNESS_RESET;

   color_type   color_queue[$];
   int unsigned cycle_count = 0;
   int unsigned fail_count = 0;
   int unsigned items_sent = 0;
   int unsigned colors_checked = 0;
   int unsigned settings_used = 1;
   bit          no_idle = 1'b0;

   // levels straddling each sector edge: last of the lower sector, first of the next
   const frac_type SECTOR_EDGES[6] = '{16'd48732, 16'd48731, 16'd31928, 16'd31927,
                                       16'd15124, 16'd15123};

   heatmap_hue_to_rgb i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_level (req_level),
      .rsp_valid (rsp_valid),
      .rsp_red   (rsp_red),
      .rsp_green (rsp_green),
      .rsp_blue  (rsp_blue),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // hard stop in case the pipeline hangs or drops results
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d colours still pending",
                  cycle_count, color_queue.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // component plus offset m, clamped at full scale
   function automatic frac_type add_clamped(frac_type comp, frac_type offset);
      logic [FRAC_W:0] sum;
      sum = {1'b0, comp} + {1'b0, offset};
      return sum[FRAC_W] ? HM_MAX : sum[FRAC_W-1:0];
   endfunction

   // six-sector hsv to rgb on the remapped hue, using the bench registers
   function automatic color_type predict_color(frac_type lvl);
      logic [FRAC_W:0] span;
      logic [31:0]     hue;
      logic [FRAC_W:0] ramp;
      logic [31:0]     prod;
      frac_type        chroma;
      frac_type        x_comp;
      frac_type        offset;
      frac_type        r;
      frac_type        g;
      frac_type        b;
      int              sector;
      color_type       col;
      span = HM_ONE - {1'b0, lvl};
      hue = (32'(span) * 32'd39) / 32'd10;          // (1 - level) * 0.65 * 360 / 60
      sector = int'(hue >> 16);
      // rising ramp in even sectors, falling ramp in odd ones
      ramp = sector[0] ? HM_ONE - {1'b0, hue[15:0]} : {1'b0, hue[15:0]};
      prod = 32'(cfg_brightness) * 32'(cfg_saturation);
      chroma = prod[31:16];
      prod = 32'(chroma) * 32'(ramp);
      x_comp = prod[31:16];
      offset = cfg_brightness - chroma;
      case (sector)
         HUE_RED_YELLOW: begin
            r = chroma; g = x_comp; b = '0;
         end
         HUE_YELLOW_GREEN: begin
            r = x_comp; g = chroma; b = '0;
         end
         HUE_GREEN_CYAN: begin
            r = '0; g = chroma; b = x_comp;
         end
         HUE_CYAN_BLUE: begin
            r = '0; g = x_comp; b = chroma;
         end
         HUE_BLUE_MAGENTA: begin
            r = x_comp; g = '0; b = chroma;
         end
         HUE_MAGENTA_RED: begin
            r = chroma; g = '0; b = x_comp;
         end
         default: begin
            // hue past the last sector comes out black before the offset
            r = '0; g = '0; b = '0;
         end
      endcase
      col.red = add_clamped(r, offset);
      col.green = add_clamped(g, offset);
      col.blue = add_clamped(b, offset);
      return col;
   endfunction

   function automatic void report_failure(string what);
      fail_count++;
      if (fail_count <= MAX_REPORTS)
         $display("mismatch at cycle %0d: %s", cycle_count, what);
   endfunction

   function automatic void check_field(string name, frac_type expected, frac_type actual);
      if (actual !== expected)
         report_failure($sformatf("%s expected %0d got %0d (colour #%0d)",
                                  name, expected, actual, colors_checked));
   endfunction

   // result checker: every strobe must match the oldest pending colour
   always @(posedge clock) begin
      color_type want;
      if (!reset && rsp_valid !== 1'b0) begin
         if (color_queue.size() == 0) begin
            report_failure($sformatf("unexpected result r=%0d g=%0d b=%0d",
                                     rsp_red, rsp_green, rsp_blue));
         end else begin
            want = color_queue.pop_front();
            check_field("red", want.red, rsp_red);
            check_field("green", want.green, rsp_green);
            check_field("blue", want.blue, rsp_blue);
            colors_checked++;
         end
      end
   end

   // idle length between items: mostly none or short, a few long
   function automatic int unsigned pick_gap();
      int unsigned roll;
      if (no_idle)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 50)
         return 0;
      else if (roll < 85)
         return $urandom_range(1, 3);
      else if (roll < 97)
         return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // send one item; called and returns at a falling edge
   task automatic send_level(frac_type lvl);
      color_type col;
      int unsigned gap;
      req_level <= lvl;
      start <= 1'b1;
      do
         @(posedge clock);
      while (busy !== 1'b0);
      col = predict_color(lvl);
      @(negedge clock);
      // queued after the accepting edge so the checker never races the push
      color_queue = {color_queue, col};
      items_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // stop sending and let every pending colour come out
   task automatic drain_pipeline();
      start <= 1'b0;
      while (color_queue.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // write both registers while idle, then let chroma and m settle
   task automatic set_colors(frac_type sat, frac_type bright);
      drain_pipeline();
      csr_we <= 1'b1;
      csr_index <= CSR_SATURATION;
      csr_wdata <= sat;
      @(negedge clock);
      csr_index <= CSR_BRIGHTNESS;
      csr_wdata <= bright;
      @(negedge clock);
      csr_we <= 1'b0;
      cfg_saturation = sat;
      cfg_brightness = bright;
      settings_used++;
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // register value biased toward the extremes
   function automatic frac_type pick_setting();
      int unsigned roll;
      roll = $urandom_range(0, 9);
      if (roll < 2)
         return '0;
      else if (roll < 4)
         return HM_MAX;
      return frac_type'($urandom_range(0, 65535));
   endfunction

   // level mix: mostly uniform, some at the ends and around sector edges
   function automatic frac_type pick_level();
      int unsigned roll;
      int          near;
      roll = $urandom_range(0, 99);
      if (roll < 5)
         return frac_type'($urandom_range(0, 3));
      else if (roll < 10)
         return frac_type'($urandom_range(65532, 65535));
      else if (roll < 20) begin
         near = int'(SECTOR_EDGES[$urandom_range(0, 5)]) + $urandom_range(0, 6) - 3;
         return frac_type'(near);
      end
      return frac_type'($urandom_range(0, 65535));
   endfunction

   // reset values of 0.8 must be in effect before any write
   task automatic test_reset_defaults();
      send_level('0);
      send_level(HM_MAX);
      send_level(16'd1);
      send_level(16'd32768);
      drain_pipeline();
   endtask

   // hue just below and just above each sector boundary
   task automatic test_sector_edges();
      foreach (SECTOR_EDGES[i])
         send_level(SECTOR_EDGES[i]);
      drain_pipeline();
   endtask

   // saturation and brightness at their extremes, incl. grey and black
   task automatic test_register_extremes();
      frac_type sats[4] = '{16'd0, HM_MAX, HM_MAX, 16'd0};
      frac_type brights[4] = '{HM_MAX, 16'd0, HM_MAX, 16'd0};
      for (int i = 0; i < 4; i++) begin
         set_colors(sats[i], brights[i]);
         send_level('0);
         send_level(HM_MAX);
         send_level(16'd40000);
      end
   endtask

   // long random streams, new register setting per phase
   task automatic test_random_stream();
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         set_colors(pick_setting(), pick_setting());
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // every 32 items maybe switch to a back-to-back stretch
            if (n % 32 == 0)
               no_idle = ($urandom_range(0, 3) == 0);
            send_level(pick_level());
         end
         no_idle = 1'b0;
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_defaults();
      test_sector_edges();
      test_register_extremes();
      test_random_stream();

      // wait out the last results, then keep watching for strays
      drain_pipeline();
      repeat (PIPE_DEPTH + 4) @(posedge clock);

      $display("sent %0d levels over %0d register settings, checked %0d colours",
               items_sent, settings_used, colors_checked);
      $display("%0d failures, %0d colours left unmatched", fail_count, color_queue.size());
      if (fail_count == 0 && color_queue.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
design/hm_pkg.sv
design/heatmap_hue_to_rgb.sv
sim/heatmap_hue_to_rgb_tb.sv
